@@ rtl/mma_pkg.sv @@
package mma_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_SIZE_W = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CFG_SIZE_W-1:0] MATRIX_SIZE_RESET = 4'd8;

    typedef enum logic {
        REG_MATRIX_SIZE = 1'b0,
        REG_NONE        = 1'b1
    } t_reg_index;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_RUN,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_term_ctl;

endpackage

@@ rtl/mma_mac.sv @@
module mma_mac
    import mma_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [DATA_W-1:0] i_a,
    input  logic [DATA_W-1:0] i_b,
    input  t_term_ctl         i_ctl,
    input  logic              i_take,
    output logic [DATA_W-1:0] o_acc,
    output logic              o_done
);

    logic [DATA_W-1:0] r_prod;
    t_term_ctl         r_ctl;
    logic [DATA_W-1:0] r_acc;
    logic              r_done;
    logic [DATA_W-1:0] w_prod;

    // low word of the product, same for signed and unsigned operands
    assign w_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl <= i_ctl;
            if (r_ctl.valid && r_ctl.last) begin
                r_done <= 1'b1;
            end else if (i_take) begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl.valid) begin
            r_acc <= (r_ctl.first ? '0 : r_acc) + r_prod;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

@@ rtl/matrix_multiply_add_core.sv @@
// Streams in n*n elements of A then n*n elements of B (row-major, one per cycle while
// s_axis_tready is high) and then emits C = A*B + A row-major with tlast on the final
// element; all arithmetic wraps to 32 bits. Both matrices sit in single-port-read
// memories, and one multiply-accumulate unit walks the n+1 terms of each result
// (n products plus the A[i][j] term); no input is taken during the emission.
// matrix_size is written over APB at address 0 (0 acts as 1, above MAX_SIZE acts
// as MAX_SIZE) and a write drops any partly loaded pair.
module matrix_multiply_add_core
    import mma_pkg::*;
#(
    parameter int MAX_SIZE = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // element
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_W-1:0]     s_axis_tdata,     // [31:0] element
    // result
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DATA_W-1:0]     m_axis_tdata,     // [31:0] result
    output logic                  m_axis_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(MAX_SIZE + 1);
    localparam int LW    = $clog2(2 * DEPTH + 1);

    t_state r_state, n_state;

    logic [CFG_SIZE_W-1:0] r_size;
    logic [LW-1:0]         r_load_cnt;
    logic [SW-1:0]         r_i, r_j, r_k;
    logic [AW:0]           r_row_base, r_k_base;
    logic [DATA_W-1:0]     r_a_rd, r_b_rd;
    t_term_ctl             r_s1_ctl;
    logic [DATA_W-1:0]     r_out_data;
    logic                  r_out_last;
    logic                  r_out_valid;

    logic [DATA_W-1:0] mem_a [DEPTH];
    logic [DATA_W-1:0] mem_b [DEPTH];

    logic [SW-1:0]     w_n;
    logic [LW-1:0]     w_nn;
    logic [LW:0]       w_cnt_inc;
    logic              w_cfg_wr;
    logic              w_accept;
    logic              w_load_done;
    logic              w_wr_a;
    logic [LW-1:0]     w_b_off;
    logic              w_issue;
    logic              w_k_end;
    logic              w_take;
    logic              w_last_elem;
    logic              w_row_end;
    logic [AW:0]       w_a_addr, w_b_addr;
    logic [DATA_W-1:0] w_mac_b;
    t_term_ctl         w_ctl;
    logic [DATA_W-1:0] w_acc;
    logic              w_done;

    // configuration
    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (t_reg_index'(paddr[2]) == REG_MATRIX_SIZE);
    assign pready   = 1'b1;
    assign prdata   = (t_reg_index'(paddr[2]) == REG_MATRIX_SIZE)
                      ? APB_DATA_W'(r_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= MATRIX_SIZE_RESET;
        end else if (w_cfg_wr) begin
            r_size <= pwdata[CFG_SIZE_W-1:0];
        end
    end

    always_comb begin
        if (r_size == '0) begin
            w_n = SW'(1);
        end else if (int'(r_size) > MAX_SIZE) begin
            w_n = SW'(MAX_SIZE);
        end else begin
            w_n = SW'(r_size);
        end
    end

    assign w_nn        = LW'(w_n) * LW'(w_n);
    assign w_accept    = s_axis_tvalid && s_axis_tready;
    assign w_cnt_inc   = {1'b0, r_load_cnt} + (LW+1)'(1);
    assign w_load_done = w_accept && (w_cnt_inc == {w_nn, 1'b0});
    assign w_wr_a      = r_load_cnt < w_nn;
    assign w_b_off     = r_load_cnt - w_nn;

    // term sequencing
    assign w_k_end     = r_k == w_n;
    assign w_row_end   = r_j == w_n - SW'(1);
    assign w_last_elem = w_row_end && (r_i == w_n - SW'(1));
    assign w_a_addr    = w_k_end ? r_row_base + (AW+1)'(r_j) : r_row_base + (AW+1)'(r_k);
    assign w_b_addr    = r_k_base + (AW+1)'(r_j);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_load_done) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_k_end) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_take) begin
                    n_state = w_last_elem ? ST_LOAD : ST_RUN;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        w_issue       = 1'b0;
        w_take        = 1'b0;
        case (r_state)
            ST_LOAD: s_axis_tready = 1'b1;
            ST_RUN:  w_issue = 1'b1;
            ST_WAIT: w_take = w_done && (!r_out_valid || m_axis_tready);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_cnt <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_row_base <= '0;
            r_k_base   <= '0;
            r_s1_ctl   <= '0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr || w_load_done) begin
                r_load_cnt <= '0;
            end else if (w_accept) begin
                r_load_cnt <= w_cnt_inc[LW-1:0];
            end

            if (w_load_done) begin
                r_i        <= '0;
                r_j        <= '0;
                r_k        <= '0;
                r_row_base <= '0;
                r_k_base   <= '0;
            end else if (w_issue && !w_k_end) begin
                r_k      <= r_k + SW'(1);
                r_k_base <= r_k_base + (AW+1)'(w_n);
            end else if (w_take) begin
                r_k      <= '0;
                r_k_base <= '0;
                if (w_row_end) begin
                    r_j        <= '0;
                    r_i        <= r_i + SW'(1);
                    r_row_base <= r_row_base + (AW+1)'(w_n);
                end else begin
                    r_j <= r_j + SW'(1);
                end
            end

            r_s1_ctl.valid <= w_issue;
            r_s1_ctl.first <= r_k == '0;
            r_s1_ctl.last  <= w_k_end;
        end
    end

    // matrix stores
    always_ff @(posedge i_clk) begin
        if (w_accept && w_wr_a) begin
            mem_a[r_load_cnt[AW-1:0]] <= s_axis_tdata;
        end
        r_a_rd <= mem_a[w_a_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && !w_wr_a) begin
            mem_b[w_b_off[AW-1:0]] <= s_axis_tdata;
        end
        r_b_rd <= mem_b[w_b_addr[AW-1:0]];
    end

    // the A[i][j] term goes through the multiplier times one
    assign w_mac_b = r_s1_ctl.last ? DATA_W'(1) : r_b_rd;
    assign w_ctl   = r_s1_ctl;

    mma_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_a     (r_a_rd),
        .i_b     (w_mac_b),
        .i_ctl   (w_ctl),
        .i_take  (w_take),
        .o_acc   (w_acc),
        .o_done  (w_done)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data <= w_acc;
            r_out_last <= w_last_elem;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule
